FILE: rtl/core/fmp_pkg.sv
// fmp_pkg: shared constants, types and modular helpers for the tiling counter
// used by fmp_modmul, fibonacci_mod_prime and fmp_checker; no dependencies
package fmp_pkg;

   localparam int RES_BITS = 30;

   localparam logic [RES_BITS-1:0] TILE_PRIME     = 30'd1000000007;
   localparam logic [31:0]         TILE_PRIME_X2  = 32'd2000000014;
   // floor(2^60 / prime), barrett reciprocal
   localparam logic [30:0]         BARRETT_MU     = 31'd1152921496;
   localparam logic [RES_BITS-1:0] TILE_PRIME_MAX = 30'd1000000006;

   typedef struct packed {
      logic                start;
      logic [RES_BITS-1:0] op_a;
      logic [RES_BITS-1:0] op_b;
   } mm_req_type;

   typedef struct packed {
      logic                done;
      logic [RES_BITS-1:0] product;
   } mm_rsp_type;

   function automatic logic [RES_BITS-1:0] mod_add(input logic [RES_BITS-1:0] a,
                                                   input logic [RES_BITS-1:0] b);
      logic [RES_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, TILE_PRIME}) begin
         s = s - {1'b0, TILE_PRIME};
      end
      return s[RES_BITS-1:0];
   endfunction

   function automatic logic [RES_BITS-1:0] mod_sub(input logic [RES_BITS-1:0] a,
                                                   input logic [RES_BITS-1:0] b);
      logic [RES_BITS:0] s;
      if (a >= b) begin
         s = {1'b0, a} - {1'b0, b};
      end else begin
         s = {1'b0, a} + {1'b0, TILE_PRIME} - {1'b0, b};
      end
      return s[RES_BITS-1:0];
   endfunction

endpackage

FILE: rtl/core/fmp_modmul.sv
// fmp_modmul: modular product a*b mod prime with barrett reduction
// one 31x31 multiplier used three times per product; depends on fmp_pkg
module fmp_modmul (
   input  logic              clock,
   input  logic              reset,
   input  fmp_pkg::mm_req_type mm_req,
   output fmp_pkg::mm_rsp_type mm_rsp
);

   typedef enum logic [4:0] {
      MM_IDLE = 5'b00001,
      MM_MUL  = 5'b00010,
      MM_EST  = 5'b00100,
      MM_BACK = 5'b01000,
      MM_FIX  = 5'b10000
   } mm_state_type;

   mm_state_type state_ff, state_in;
   logic         done_ff, done_in;

   logic [fmp_pkg::RES_BITS-1:0] op_a_ff, op_a_in;
   logic [fmp_pkg::RES_BITS-1:0] op_b_ff, op_b_in;
   logic [61:0]                  prod_ff, prod_in;
   logic [31:0]                  x_ff, x_in;
   logic [fmp_pkg::RES_BITS-1:0] result_ff, result_in;

   logic [30:0] mul_a;
   logic [30:0] mul_b;
   logic [61:0] mul_p;
   logic [31:0] diff;

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         MM_MUL: begin
            mul_a = {1'b0, op_a_ff};
            mul_b = {1'b0, op_b_ff};
         end
         MM_EST: begin
            mul_a = prod_ff[59:29];
            mul_b = fmp_pkg::BARRETT_MU;
         end
         MM_BACK: begin
            mul_a = prod_ff[61:31];
            mul_b = {1'b0, fmp_pkg::TILE_PRIME};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign diff  = x_ff - prod_ff[31:0];

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      op_a_in   = op_a_ff;
      op_b_in   = op_b_ff;
      prod_in   = prod_ff;
      x_in      = x_ff;
      result_in = result_ff;
      case (state_ff)
         MM_IDLE: begin
            if (mm_req.start) begin
               op_a_in  = mm_req.op_a;
               op_b_in  = mm_req.op_b;
               state_in = MM_MUL;
            end
         end
         MM_MUL: begin
            prod_in  = mul_p;
            state_in = MM_EST;
         end
         MM_EST: begin
            x_in     = prod_ff[31:0];
            prod_in  = mul_p;
            state_in = MM_BACK;
         end
         MM_BACK: begin
            prod_in  = mul_p;
            state_in = MM_FIX;
         end
         MM_FIX: begin
            // remainder estimate is below three times the prime
            if (diff >= fmp_pkg::TILE_PRIME_X2) begin
               result_in = 30'(diff - fmp_pkg::TILE_PRIME_X2);
            end else if (diff >= {2'b00, fmp_pkg::TILE_PRIME}) begin
               result_in = 30'(diff - {2'b00, fmp_pkg::TILE_PRIME});
            end else begin
               result_in = diff[fmp_pkg::RES_BITS-1:0];
            end
            done_in  = 1'b1;
            state_in = MM_IDLE;
         end
         default: begin
            state_in = MM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MM_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff   <= op_a_in;
      op_b_ff   <= op_b_in;
      prod_ff   <= prod_in;
      x_ff      <= x_in;
      result_ff <= result_in;
   end

   assign mm_rsp.done    = done_ff;
   assign mm_rsp.product = result_ff;

endmodule

FILE: rtl/core/fibonacci_mod_prime.sv
// fibonacci_mod_prime: 2 by n domino tiling count, F(n+1) mod 1000000007
// fibonacci matrix power by square and multiply; depends on fmp_pkg, fmp_modmul
//
//  channel   ports                                   transfer
//  request   start, busy, req_tile_length            start high while busy low
//  response  rsp_valid, rsp_tiling_count             rsp_valid high, one cycle
//
// one modular product takes three passes of the shared 31x31 multiplier
// one 2x2 matrix step takes four products (matrices kept symmetric)
// an item takes one matrix step per squaring and per multiply from transfer to strobe,
// squarings one fewer than the bits of n-1, multiplies its set bits
// busy is high from the cycle after a transfer until the result strobe
// synchronous reset returns to idle; the result strobe cannot be stalled
module fibonacci_mod_prime #(
   parameter int LENGTH_BITS = 63
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [LENGTH_BITS-1:0]       req_tile_length,
   output logic                         rsp_valid,
   output logic [fmp_pkg::RES_BITS-1:0] rsp_tiling_count
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_STEP  = 7'b0000010,
      ST_PREP  = 7'b0000100,
      ST_ISSUE = 7'b0001000,
      ST_WAIT  = 7'b0010000,
      ST_STORE = 7'b0100000,
      ST_FINAL = 7'b1000000
   } fmp_state_type;

   fmp_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          bit_done_ff, bit_done_in;
   logic          is_sqr_ff, is_sqr_in;
   logic [1:0]    idx_ff, idx_in;

   logic [LENGTH_BITS-1:0]       k_ff, k_in;
   // matrices held as (off-diagonal, lower-right); upper-left is their difference
   logic [fmp_pkg::RES_BITS-1:0] acc_b_ff, acc_b_in, acc_d_ff, acc_d_in;
   logic [fmp_pkg::RES_BITS-1:0] base_b_ff, base_b_in, base_d_ff, base_d_in;
   logic [fmp_pkg::RES_BITS-1:0] xa_ff, xa_in;
   logic [fmp_pkg::RES_BITS-1:0] sum_ff, sum_in;
   logic [fmp_pkg::RES_BITS-1:0] new_b_ff, new_b_in;
   logic [fmp_pkg::RES_BITS-1:0] count_ff, count_in;

   logic [fmp_pkg::RES_BITS-1:0] x_b;
   logic [fmp_pkg::RES_BITS-1:0] x_d;
   logic [fmp_pkg::RES_BITS-1:0] new_d;

   fmp_pkg::mm_req_type mm_req;
   fmp_pkg::mm_rsp_type mm_rsp;

   fmp_modmul u_modmul (
      .clock  (clock),
      .reset  (reset),
      .mm_req (mm_req),
      .mm_rsp (mm_rsp)
   );

   assign x_b   = is_sqr_ff ? base_b_ff : acc_b_ff;
   assign x_d   = is_sqr_ff ? base_d_ff : acc_d_ff;
   assign new_d = fmp_pkg::mod_add(sum_ff, mm_rsp.product);

   // operand pairs: a*yb, b*yd, b*yb, d*yd
   always_comb begin
      mm_req.start = (state_ff == ST_ISSUE);
      case (idx_ff)
         2'd0: begin
            mm_req.op_a = xa_ff;
            mm_req.op_b = base_b_ff;
         end
         2'd1: begin
            mm_req.op_a = x_b;
            mm_req.op_b = base_d_ff;
         end
         2'd2: begin
            mm_req.op_a = x_b;
            mm_req.op_b = base_b_ff;
         end
         default: begin
            mm_req.op_a = x_d;
            mm_req.op_b = base_d_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      bit_done_in  = bit_done_ff;
      is_sqr_in    = is_sqr_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      acc_b_in     = acc_b_ff;
      acc_d_in     = acc_d_ff;
      base_b_in    = base_b_ff;
      base_d_in    = base_d_ff;
      xa_in        = xa_ff;
      sum_in       = sum_ff;
      new_b_in     = new_b_ff;
      count_in     = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_tile_length == '0) begin
                  k_in = '0;
               end else begin
                  k_in = req_tile_length - LENGTH_BITS'(1);
               end
               acc_b_in    = '0;
               acc_d_in    = 30'd1;
               base_b_in   = 30'd1;
               base_d_in   = 30'd1;
               bit_done_in = 1'b0;
               state_in    = ST_STEP;
            end
         end
         ST_STEP: begin
            if (k_ff[0] && !bit_done_ff) begin
               is_sqr_in = 1'b0;
               state_in  = ST_PREP;
            end else if (k_ff[LENGTH_BITS-1:1] == '0) begin
               state_in = ST_FINAL;
            end else begin
               is_sqr_in = 1'b1;
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            xa_in    = fmp_pkg::mod_sub(x_d, x_b);
            idx_in   = 2'd0;
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (mm_rsp.done) begin
               case (idx_ff)
                  2'd0, 2'd2: sum_in = mm_rsp.product;
                  2'd1:       new_b_in = fmp_pkg::mod_add(sum_ff, mm_rsp.product);
                  default:    sum_in = sum_ff;
               endcase
               if (idx_ff == 2'd3) begin
                  state_in = ST_STORE;
               end else begin
                  idx_in   = idx_ff + 2'd1;
                  state_in = ST_ISSUE;
               end
            end
         end
         ST_STORE: begin
            if (is_sqr_ff) begin
               base_b_in   = new_b_ff;
               base_d_in   = new_d;
               k_in        = k_ff >> 1;
               bit_done_in = 1'b0;
            end else begin
               acc_b_in    = new_b_ff;
               acc_d_in    = new_d;
               bit_done_in = 1'b1;
            end
            state_in = ST_STEP;
         end
         ST_FINAL: begin
            // m00 + 2*m10 equals lower-right plus off-diagonal
            count_in     = fmp_pkg::mod_add(acc_d_ff, acc_b_ff);
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_done_ff  <= 1'b0;
         is_sqr_ff    <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bit_done_ff  <= bit_done_in;
         is_sqr_ff    <= is_sqr_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff      <= k_in;
      acc_b_ff  <= acc_b_in;
      acc_d_ff  <= acc_d_in;
      base_b_ff <= base_b_in;
      base_d_ff <= base_d_in;
      xa_ff     <= xa_in;
      sum_ff    <= sum_in;
      new_b_ff  <= new_b_in;
      count_ff  <= count_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tiling_count = count_ff;

endmodule

FILE: rtl/core/fmp_checker.sv
// fmp_checker: port-level assertions for fibonacci_mod_prime, bound to the top level
// depends on fmp_pkg
module fmp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         rsp_valid,
   input logic [fmp_pkg::RES_BITS-1:0] rsp_tiling_count
);

   // an accepted request makes the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request transfer did not raise busy");

   // a result arrives exactly when busy drops
   a_result_on_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_result_only_on_fall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $fell(busy))
      else $error("result strobe outside end of work");

   // result is fully reduced
   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tiling_count <= fmp_pkg::TILE_PRIME_MAX))
      else $error("result not reduced below the prime");

endmodule

bind fibonacci_mod_prime fmp_checker u_fmp_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_tiling_count (rsp_tiling_count)
);

FILE: tb/sv/fmp_checker.sv
// fmp_tb_checker: watches the length and count channels of fibonacci_mod_prime,
// predicts each tiling count by 2x2 matrix power mod the prime and compares
// depends on fmp_pkg for the result width and the prime
`timescale 1ns / 1ps

module fmp_tb_checker #(
   parameter int LENGTH_BITS = 63
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic                         busy,
   input  logic [LENGTH_BITS-1:0]       req_tile_length,
   input  logic                         rsp_valid,
   input  logic [fmp_pkg::RES_BITS-1:0] rsp_tiling_count,
   output int unsigned                  error_count,
   output int unsigned                  pending_count
);

   localparam int RB = fmp_pkg::RES_BITS;

   typedef struct {
      logic [RB-1:0] e00;
      logic [RB-1:0] e01;
      logic [RB-1:0] e10;
      logic [RB-1:0] e11;
   } tile_mat_type;

   logic [RB-1:0] tiling_count_q [$];
   logic [RB-1:0] expected_count;

   function automatic logic [RB-1:0] mul_mod(input logic [RB-1:0] a, input logic [RB-1:0] b);
      logic [63:0] prod;
      prod = 64'(a) * 64'(b);
      return RB'(prod % 64'(fmp_pkg::TILE_PRIME));
   endfunction

   function automatic logic [RB-1:0] add_mod(input logic [RB-1:0] a, input logic [RB-1:0] b);
      logic [63:0] sum;
      sum = 64'(a) + 64'(b);
      return RB'(sum % 64'(fmp_pkg::TILE_PRIME));
   endfunction

   function automatic tile_mat_type mat_product(input tile_mat_type x, input tile_mat_type y);
      tile_mat_type r;
      r.e00 = add_mod(mul_mod(x.e00, y.e00), mul_mod(x.e01, y.e10));
      r.e01 = add_mod(mul_mod(x.e00, y.e01), mul_mod(x.e01, y.e11));
      r.e10 = add_mod(mul_mod(x.e10, y.e00), mul_mod(x.e11, y.e10));
      r.e11 = add_mod(mul_mod(x.e10, y.e01), mul_mod(x.e11, y.e11));
      return r;
   endfunction

   function automatic logic [RB-1:0] tiling_count_of(input logic [LENGTH_BITS-1:0] len);
      tile_mat_type acc;
      tile_mat_type base;
      logic [LENGTH_BITS-1:0] k;
      if (len == '0) begin
         return RB'(1);
      end
      acc.e00 = RB'(1);
      acc.e01 = '0;
      acc.e10 = '0;
      acc.e11 = RB'(1);
      base.e00 = '0;
      base.e01 = RB'(1);
      base.e10 = RB'(1);
      base.e11 = RB'(1);
      k = len - 1'b1;
      while (k != '0) begin
         if (k[0]) begin
            acc = mat_product(acc, base);
         end
         base = mat_product(base, base);
         k = k >> 1;
      end
      return add_mod(acc.e00, mul_mod(RB'(2), acc.e10));
   endfunction

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   // result side first, so a transfer in the strobe cycle queues behind it
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            if (tiling_count_q.size() == 0) begin
               $error("tiling_count: result with none pending, actual %0d", rsp_tiling_count);
               error_count <= error_count + 1;
            end else begin
               expected_count = tiling_count_q.pop_front();
               if (rsp_tiling_count !== expected_count) begin
                  $error("tiling_count mismatch: expected %0d, actual %0d",
                         expected_count, rsp_tiling_count);
                  error_count <= error_count + 1;
               end
            end
         end
         if (start && !busy) begin
            tiling_count_q.push_back(tiling_count_of(req_tile_length));
         end
         pending_count <= tiling_count_q.size();
      end
   end

endmodule

FILE: tb/sv/testbench.sv
// testbench: drives board lengths into fibonacci_mod_prime with random gaps,
// directed extremes first, then mostly short random lengths and a few full ones
// depends on fmp_pkg, fibonacci_mod_prime and fmp_tb_checker
`timescale 1ns / 1ps

module testbench;

   localparam int          LENGTH_BITS  = 63;
   localparam int          RANDOM_ITEMS = 560;
   localparam int          DRAIN_CYCLES = 3600;
   localparam int unsigned CYCLE_LIMIT  = 10000000;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [LENGTH_BITS-1:0]       req_tile_length = '0;
   logic                         rsp_valid;
   logic [fmp_pkg::RES_BITS-1:0] rsp_tiling_count;
   int unsigned                  error_count;
   int unsigned                  pending_count;
   int unsigned                  cycle_count = 0;

   fibonacci_mod_prime #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_tile_length (req_tile_length),
      .rsp_valid       (rsp_valid),
      .rsp_tiling_count(rsp_tiling_count)
   );

   fmp_tb_checker #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_tile_length (req_tile_length),
      .rsp_valid       (rsp_valid),
      .rsp_tiling_count(rsp_tiling_count),
      .error_count     (error_count),
      .pending_count   (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_length(input logic [LENGTH_BITS-1:0] len);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start           <= 1'b1;
      req_tile_length <= len;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   function automatic logic [LENGTH_BITS-1:0] random_length();
      logic [63:0] raw;
      logic [63:0] mask;
      int          pick;
      int          width;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         width = $urandom_range(1, 16);
      end else if (pick < 85) begin
         width = $urandom_range(17, 40);
      end else begin
         width = LENGTH_BITS;
      end
      mask = (64'd1 << width) - 64'd1;
      return LENGTH_BITS'(raw & mask);
   endfunction

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_length(63'd0);
      send_length(63'd1);
      send_length(63'd2);
      send_length(63'd3);
      send_length(63'd4);
      send_length(63'd5);
      send_length(63'd6);
      send_length(63'd7);
      send_length(63'd8);
      send_length(63'd64);
      send_length(63'd65);
      send_length(63'd1000000007);
      send_length(63'd2000000015);
      send_length(63'd2000000016);
      send_length(63'h0000_0000_FFFF_FFFF);
      send_length(63'h0000_0001_0000_0000);
      send_length(63'h4000_0000_0000_0000);
      send_length(63'h4000_0000_0000_0001);
      send_length(63'h2AAA_AAAA_AAAA_AAAA);
      send_length(63'h5555_5555_5555_5555);
      send_length({LENGTH_BITS{1'b1}});

      repeat (RANDOM_ITEMS) begin
         send_length(random_length());
      end
      start <= 1'b0;

      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
